/* hdl/rlc_pkg.sv */
// shared types and fixed coefficients for the rgb/lab color converter
package rlc_pkg;

	// one color channel, signed fixed point
	typedef logic signed [23:0] chan_t;

	// configuration register map (word index)
	typedef enum logic [0:0] {
		REG_DIRECTION   = 1'b0,
		REG_WHITE_POINT = 1'b1
	} reg_index_t;

	// linear rgb to xyz, q20
	localparam logic signed [21:0] FWD_M [9] = '{
		22'sd432488, 22'sd374950, 22'sd189187,
		22'sd223002, 22'sd749900, 22'sd75675,
		22'sd20273,  22'sd124983, 22'sd996385
	};

	// xyz to linear rgb, q20
	localparam logic signed [22:0] INV_M [9] = '{
		23'sd3397889,  -23'sd1611819, -23'sd522752,
		-23'sd1016339, 23'sd1967120,  23'sd43575,
		23'sd58351,    -23'sd213955,  23'sd1108671
	};

	// d65 white, 2-degree then 10-degree, q20
	localparam logic signed [21:0] WHITE_Q20 [2][3] = '{
		'{22'sd996640, 22'sd1048576, 22'sd1141721},
		'{22'sd994165, 22'sd1048576, 22'sd1125164}
	};

	// reciprocals of the white values, q20
	localparam logic signed [21:0] WHITE_RCP_Q20 [2][3] = '{
		'{22'sd1103218, 22'sd1048576, 22'sd963030},
		'{22'sd1105965, 22'sd1048576, 22'sd977201}
	};

	// 7.787 and 903.3 at q20
	localparam logic signed [24:0] SLOPE_Q20  = 25'sd8165261;
	localparam logic signed [30:0] LSLOPE_Q20 = 31'sd947178701;

	// 0.008856 and 16/116 at q32
	localparam longint unsigned Q32_THR = 64'd38036230;
	localparam longint unsigned Q32_OFS = 64'd592409282;

	// lab divisors with their halves and q32 reciprocals
	localparam logic [8:0]  DIV_D    [3] = '{9'd116, 9'd500, 9'd200};
	localparam logic [8:0]  DIV_HALF [3] = '{9'd58, 9'd250, 9'd100};
	localparam logic [25:0] DIV_RCP  [3] = '{
		26'((64'd1 << 32) / 116),
		26'((64'd1 << 32) / 500),
		26'((64'd1 << 32) / 200)
	};

endpackage

/* hdl/rlc_ifs.sv */
// pixel stream interfaces for the color converter
interface rlc_in_if import rlc_pkg::*; ();
	logic  valid;
	logic  ready;
	chan_t chan_first;
	chan_t chan_second;
	chan_t chan_third;

	modport source (output valid, chan_first, chan_second, chan_third, input ready);
	modport sink   (input valid, chan_first, chan_second, chan_third, output ready);
endinterface

interface rlc_out_if import rlc_pkg::*; ();
	logic  valid;
	logic  ready;
	chan_t res_first;
	chan_t res_second;
	chan_t res_third;

	modport source (output valid, res_first, res_second, res_third, input ready);
	modport sink   (input valid, res_first, res_second, res_third, output ready);
endinterface

/* hdl/rgb_lab_color_convert.sv */
// pipelined linear rgb <-> cielab converter with apb configuration
//
//  port      dir  handshake          payload
//  pix_in    in   valid/ready        chan_first, chan_second, chan_third
//  pix_out   out  valid/ready        res_first, res_second, res_third
//  apb       in   psel/penable       direction, white point select
//
// one pixel per cycle while pix_out is ready; the cube root sets the pipeline depth,
// one root digit per stage, with ND = ceil((24+2*FRAC_BITS)/3) root digits.
// reset clears stage valids and sets direction 0, white point 1.
// each stage advances when it is empty or the stage after it advances, so a
// stall on pix_out fills bubbles first and then holds every stage in place.
module rgb_lab_color_convert import rlc_pkg::*; #(
	parameter int FRAC_BITS = 12
) (
	input  logic         clk,
	input  logic         arst_n,
	rlc_in_if.sink       pix_in,
	rlc_out_if.source    pix_out,
	input  logic         psel,
	input  logic         penable,
	input  logic         pwrite,
	input  logic [2:0]   paddr,
	input  logic [31:0]  pwdata,
	output logic [31:0]  prdata,
	output logic         pready
);

	localparam int F   = FRAC_BITS;
	localparam int NW  = 24 + 2 * F;
	localparam int ND  = (NW + 2) / 3;
	localparam int RW  = 2 * ND + 6;
	localparam int N   = ND + 7;
	localparam int TW  = 29;
	localparam int LW  = 35;
	localparam int LLW = 41;
	localparam int FW  = 36;
	localparam int AW  = 20;
	localparam int CUW = 3 * AW - 2 * F;
	localparam int XW  = CUW + 3;
	localparam int RRW = XW + 8;
	localparam longint HF     = longint'(1) << (F - 1);
	localparam longint HALF20 = 64'sd524288;
	localparam longint THR_L  = longint'((Q32_THR + (64'd1 << (31 - F))) >> (32 - F));
	localparam longint OFS_L  = longint'((Q32_OFS + (64'd1 << (31 - F))) >> (32 - F));
	localparam longint LOFS_L = longint'(16) << F;

	function automatic chan_t sat24(input logic signed [63:0] v);
		if (v > 64'sd8388607)
			return 24'sh7FFFFF;
		else if (v < -64'sd8388608)
			return 24'sh800000;
		else
			return v[23:0];
	endfunction

	// configuration registers
	logic dir_q;
	logic wps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q <= 1'b0;
			wps_q <= 1'b1;
		end else if (psel && penable && pwrite) begin
			case (reg_index_t'(paddr[2]))
				REG_DIRECTION:   dir_q <= pwdata[0];
				REG_WHITE_POINT: wps_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (reg_index_t'(paddr[2]))
			REG_DIRECTION:   prdata[0] = dir_q;
			REG_WHITE_POINT: prdata[0] = wps_q;
			default: ;
		endcase
	end

	assign pready = 1'b1;

	// stage valids and advance chain
	logic [N:1] vld_s;
	logic [N:1] en;
	logic [N:1] vld_in;

	assign vld_in = {vld_s[N-1:1], pix_in.valid};
	assign en[N]  = !vld_s[N] || pix_out.ready;

	for (genvar k = 1; k < N; k++) begin : g_en
		assign en[k] = !vld_s[k] || en[k+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			for (int k = 1; k <= N; k++)
				if (en[k])
					vld_s[k] <= vld_in[k];
		end
	end

	assign pix_in.ready = en[1];

	chan_t vin [3];
	assign vin[0] = pix_in.chan_first;
	assign vin[1] = pix_in.chan_second;
	assign vin[2] = pix_in.chan_third;

	// ---------------- forward path ----------------

	logic signed [44:0]   prod_s1 [3][3];
	logic signed [26:0]   w_s2 [3];
	logic signed [48:0]   wp_s3 [3];
	logic signed [TW-1:0] t_s4 [3];
	logic                 gt_s4 [3];
	logic [NW-1:0]        n_s4 [3];
	logic signed [46:0]   row_s2 [3];
	logic signed [49:0]   tr_s4 [3];

	// matrix products
	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++)
					prod_s1[i][j] <= 45'(vin[j]) * 45'(FWD_M[i*3+j]);
		end
	end

	// matrix rows
	always_comb begin
		for (int i = 0; i < 3; i++)
			row_s2[i] = 47'(prod_s1[i][0]) + 47'(prod_s1[i][1]) + 47'(prod_s1[i][2])
				+ 47'(HALF20);
	end

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int i = 0; i < 3; i++)
				w_s2[i] <= 27'(row_s2[i] >>> 20);
		end
	end

	// white normalization product
	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int i = 0; i < 3; i++)
				wp_s3[i] <= 49'(w_s2[i]) * 49'(WHITE_RCP_Q20[wps_q][i]);
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			tr_s4[i] = (50'(wp_s3[i]) + 50'(HALF20)) >>> 20;
	end

	// normalized value, branch flag and cube root operand
	always_ff @(posedge clk) begin
		if (en[4]) begin
			for (int i = 0; i < 3; i++) begin
				t_s4[i]  <= TW'(tr_s4[i]);
				gt_s4[i] <= TW'(tr_s4[i]) > TW'(THR_L);
				if (TW'(tr_s4[i]) > TW'(64'sd16777215))
					n_s4[i] <= {24'hFFFFFF, {(2*F){1'b0}}};
				else
					n_s4[i] <= {tr_s4[i][23:0], {(2*F){1'b0}}};
			end
		end
	end

	// cube root stages, index 0 holds the linear branch results
	logic [ND-1:0]         cy_s   [0:ND][3];
	logic [2*ND-1:0]       cy2_s  [0:ND][3];
	logic [RW-1:0]         crm_s  [0:ND][3];
	logic [NW-1:0]         cn_s   [0:ND][3];
	logic signed [LW-1:0]  lin_s  [0:ND][3];
	logic signed [LLW-1:0] llin_s [0:ND];
	logic                  gt_s   [0:ND][3];

	// linear branch of the lab function and of l
	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int i = 0; i < 3; i++) begin
				lin_s[0][i] <= LW'((54'(t_s4[i]) * 54'(SLOPE_Q20) + 54'(HALF20)) >>> 20)
					+ LW'(OFS_L);
				cy_s[0][i]  <= '0;
				cy2_s[0][i] <= '0;
				crm_s[0][i] <= '0;
				cn_s[0][i]  <= n_s4[i];
				gt_s[0][i]  <= gt_s4[i];
			end
			llin_s[0] <= LLW'((61'(t_s4[1]) * 61'(LSLOPE_Q20) + 61'(HALF20)) >>> 20);
		end
	end

	for (genvar j = 1; j <= ND; j++) begin : g_cbrt
		localparam int D = ND - j;
		logic [3*ND-1:0] np   [3];
		logic [RW-1:0]   rsh  [3];
		logic [RW-1:0]   cand [3];
		logic [ND-1:0]   yd   [3];
		logic [2*ND-1:0] y2d  [3];
		logic            take [3];

		// one root digit: bring down three bits, try the next root bit
		always_comb begin
			for (int c = 0; c < 3; c++) begin
				np[c]   = (3*ND)'(cn_s[j-1][c]);
				rsh[c]  = (crm_s[j-1][c] << 3) | RW'(np[c][3*D +: 3]);
				yd[c]   = cy_s[j-1][c] << 1;
				y2d[c]  = cy2_s[j-1][c] << 2;
				cand[c] = (RW'(y2d[c]) << 1) + RW'(y2d[c]) + (RW'(yd[c]) << 1)
					+ RW'(yd[c]) + RW'(1);
				take[c] = rsh[c] >= cand[c];
			end
		end

		always_ff @(posedge clk) begin
			if (en[5+j]) begin
				for (int c = 0; c < 3; c++) begin
					if (take[c]) begin
						cy_s[j][c]  <= yd[c] | ND'(1);
						cy2_s[j][c] <= y2d[c] + ((2*ND)'(yd[c]) << 1) + (2*ND)'(1);
						crm_s[j][c] <= rsh[c] - cand[c];
					end else begin
						cy_s[j][c]  <= yd[c];
						cy2_s[j][c] <= y2d[c];
						crm_s[j][c] <= rsh[c];
					end
				end
				cn_s[j]   <= cn_s[j-1];
				lin_s[j]  <= lin_s[j-1];
				gt_s[j]   <= gt_s[j-1];
				llin_s[j] <= llin_s[j-1];
			end
		end
	end

	// l, a and b
	logic signed [FW-1:0] fsel [3];
	logic signed [47:0]   lab_spost [3];

	always_comb begin
		for (int c = 0; c < 3; c++)
			fsel[c] = gt_s[ND][c] ? FW'($signed({1'b0, cy_s[ND][c]})) : FW'(lin_s[ND][c]);
	end

	always_ff @(posedge clk) begin
		if (en[N-1]) begin
			if (gt_s[ND][1])
				lab_spost[0] <= 48'(fsel[1]) * 48'sd116 - 48'(LOFS_L);
			else
				lab_spost[0] <= 48'(llin_s[ND]);
			lab_spost[1] <= (48'(fsel[0]) - 48'(fsel[1])) * 48'sd500;
			lab_spost[2] <= (48'(fsel[1]) - 48'(fsel[2])) * 48'sd200;
		end
	end

	// ---------------- reverse path ----------------

	logic signed [25:0]    sv [3];
	logic [25:0]           rmag [3];
	logic [25:0]           rm_s1 [3];
	logic                  rneg_s1 [3];
	logic [51:0]           rp_s2 [3];
	logic [25:0]           rm_s2 [3];
	logic                  rneg_s2 [3];
	logic [19:0]           qe [3];
	logic [25:0]           rem [3];
	logic [19:0]           qf [3];
	logic signed [20:0]    rq_s3 [3];
	logic signed [AW-1:0]  ra_s4 [3];
	logic signed [2*AW-1:0] sq_s5 [3];
	logic signed [AW-1:0]  ra_s5 [3];
	logic signed [2*AW-F-1:0] rs_s6 [3];
	logic signed [AW-1:0]  ra_s6 [3];
	logic signed [3*AW-F-1:0] cb_s7 [3];
	logic signed [CUW-1:0] cu_s8 [3];
	logic signed [38:0]    wl_s9 [3];
	logic signed [CUW+5:0] wh_s9 [3];
	logic signed [XW-1:0]  x_s10 [3];
	logic signed [39:0]    ml_s11 [3][3];
	logic signed [XW+6:0]  mh_s11 [3][3];
	logic signed [RRW-1:0] rr_s12 [3];
	chan_t                 rsat_s13 [3];
	logic signed [XW+27:0] rsum [3];

	// sign and magnitude plus half divisor
	always_comb begin
		sv[0] = 26'(vin[0]) + 26'(LOFS_L);
		sv[1] = 26'(vin[1]);
		sv[2] = 26'(vin[2]);
		for (int c = 0; c < 3; c++)
			rmag[c] = sv[c] < 0 ? 26'(-sv[c]) : 26'(sv[c]);
	end

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int c = 0; c < 3; c++) begin
				rm_s1[c]   <= rmag[c] + 26'(DIV_HALF[c]);
				rneg_s1[c] <= sv[c] < 0;
			end
		end
	end

	// reciprocal multiply
	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int c = 0; c < 3; c++) begin
				rp_s2[c]   <= 52'(rm_s1[c]) * 52'(DIV_RCP[c]);
				rm_s2[c]   <= rm_s1[c];
				rneg_s2[c] <= rneg_s1[c];
			end
		end
	end

	// quotient correction and sign
	always_comb begin
		for (int c = 0; c < 3; c++) begin
			qe[c]  = rp_s2[c][51:32];
			rem[c] = rm_s2[c] - 26'(qe[c]) * 26'(DIV_D[c]);
			qf[c]  = rem[c] >= 26'(DIV_D[c]) ? qe[c] + 20'd1 : qe[c];
		end
	end

	always_ff @(posedge clk) begin
		if (en[3]) begin
			for (int c = 0; c < 3; c++)
				rq_s3[c] <= rneg_s2[c] ? -$signed({1'b0, qf[c]}) : $signed({1'b0, qf[c]});
		end
	end

	// cube arguments
	always_ff @(posedge clk) begin
		if (en[4]) begin
			ra_s4[0] <= AW'(rq_s3[0]) + AW'(rq_s3[1]);
			ra_s4[1] <= AW'(rq_s3[0]);
			ra_s4[2] <= AW'(rq_s3[0]) - AW'(rq_s3[2]);
		end
	end

	// cubing: square, round, multiply, round
	always_ff @(posedge clk) begin
		if (en[5]) begin
			for (int c = 0; c < 3; c++) begin
				sq_s5[c] <= (2*AW)'(ra_s4[c]) * (2*AW)'(ra_s4[c]);
				ra_s5[c] <= ra_s4[c];
			end
		end
		if (en[6]) begin
			for (int c = 0; c < 3; c++) begin
				rs_s6[c] <= (2*AW-F)'((sq_s5[c] + (2*AW)'(HF)) >>> F);
				ra_s6[c] <= ra_s5[c];
			end
		end
		if (en[7]) begin
			for (int c = 0; c < 3; c++)
				cb_s7[c] <= (3*AW-F)'(rs_s6[c]) * (3*AW-F)'(ra_s6[c]);
		end
		if (en[8]) begin
			for (int c = 0; c < 3; c++)
				cu_s8[c] <= CUW'((cb_s7[c] + (3*AW-F)'(HF)) >>> F);
		end
	end

	// white scaling as low and high partial products
	always_ff @(posedge clk) begin
		if (en[9]) begin
			for (int c = 0; c < 3; c++) begin
				wl_s9[c] <= 39'($signed({1'b0, cu_s8[c][15:0]})) * 39'(WHITE_Q20[wps_q][c]);
				wh_s9[c] <= (CUW+6)'(cu_s8[c] >>> 16) * (CUW+6)'(WHITE_Q20[wps_q][c]);
			end
		end
		if (en[10]) begin
			for (int c = 0; c < 3; c++)
				x_s10[c] <= XW'((((CUW+24)'(wh_s9[c]) <<< 16) + (CUW+24)'(wl_s9[c])
					+ (CUW+24)'(HALF20)) >>> 20);
		end
	end

	// inverse matrix as low and high partial products
	always_ff @(posedge clk) begin
		if (en[11]) begin
			for (int i = 0; i < 3; i++)
				for (int j = 0; j < 3; j++) begin
					ml_s11[i][j] <= 40'($signed({1'b0, x_s10[j][15:0]}))
						* 40'(INV_M[i*3+j]);
					mh_s11[i][j] <= (XW+7)'(x_s10[j] >>> 16) * (XW+7)'(INV_M[i*3+j]);
				end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++)
			rsum[i] = ((XW+28)'(mh_s11[i][0]) <<< 16) + (XW+28)'(ml_s11[i][0])
				+ ((XW+28)'(mh_s11[i][1]) <<< 16) + (XW+28)'(ml_s11[i][1])
				+ ((XW+28)'(mh_s11[i][2]) <<< 16) + (XW+28)'(ml_s11[i][2])
				+ (XW+28)'(HALF20);
	end

	always_ff @(posedge clk) begin
		if (en[12]) begin
			for (int i = 0; i < 3; i++)
				rr_s12[i] <= RRW'(rsum[i] >>> 20);
		end
		if (en[13]) begin
			for (int i = 0; i < 3; i++)
				rsat_s13[i] <= sat24(64'(rr_s12[i]));
		end
	end

	// delay reverse results to the forward latency
	chan_t rdl_s [14:N-1][3];

	for (genvar k = 14; k < N; k++) begin : g_rdl
		if (k == 14) begin : g_first
			always_ff @(posedge clk) begin
				if (en[k])
					rdl_s[k] <= rsat_s13;
			end
		end else begin : g_next
			always_ff @(posedge clk) begin
				if (en[k])
					rdl_s[k] <= rdl_s[k-1];
			end
		end
	end

	// output register
	chan_t res_sout [3];

	always_ff @(posedge clk) begin
		if (en[N]) begin
			for (int c = 0; c < 3; c++)
				res_sout[c] <= dir_q ? rdl_s[N-1][c] : sat24(64'(lab_spost[c]));
		end
	end

	assign pix_out.valid      = vld_s[N];
	assign pix_out.res_first  = res_sout[0];
	assign pix_out.res_second = res_sout[1];
	assign pix_out.res_third  = res_sout[2];

	// any empty stage lets a transfer in
	a_ready_when_room: assert property (@(posedge clk) disable iff (!arst_n)
		!(&vld_s) |-> pix_in.ready)
		else $error("input stalled with an empty stage");

	// root square tracks the root
	a_root_square: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[5+ND] |-> cy2_s[ND][1] == (2*ND)'(cy_s[ND][1]) * (2*ND)'(cy_s[ND][1]))
		else $error("cube root square out of step");

	// root cubed plus remainder gives the operand back
	a_root_exact: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s[5+ND] |-> (3*ND)'(cn_s[ND][1]) == (3*ND)'(cy_s[ND][1]) * (3*ND)'(cy_s[ND][1])
			* (3*ND)'(cy_s[ND][1]) + (3*ND)'(crm_s[ND][1]))
		else $error("cube root remainder mismatch");

endmodule
